@@ rtl/ifw_pkg.sv @@
// shared types and constants for the id3v2 frame walker
`default_nettype none
package ifw_pkg;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned ID_W      = 32;
	localparam int unsigned SIZE_W    = 28;
	localparam int unsigned POS_W     = 32;
	localparam int unsigned FIELD_W   = 4;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [ID_W-1:0]    CHOSEN_ID_RESET = 32'h4150_4943;
	localparam logic [FIELD_W-1:0] HDR_LAST        = 4'd9;
	localparam logic [FIELD_W-1:0] VER_MAJ_IDX     = 4'd3;
	localparam logic [FIELD_W-1:0] VER_REV_IDX     = 4'd4;
	localparam logic [FIELD_W-1:0] SIZE_FIRST_IDX  = 4'd6;
	localparam logic [FIELD_W-1:0] ID_END_IDX      = 4'd4;
	localparam logic [FIELD_W-1:0] SIZE_END_IDX    = 4'd8;
	localparam logic [FIELD_W-1:0] FLAG_FIRST      = 4'd1;
	localparam logic [FIELD_W-1:0] FLAG_STOP       = 4'd2;
	localparam logic [POS_W:0]     HDR_LEN         = 33'd10;

	localparam logic [KIND_W-1:0] KIND_VERSION = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CHOSEN_ID   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE = 1'd1;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_FRAMEHD,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   frame_tag;
		logic [BYTE_W-1:0] payload_byte;
		logic              first_of_frame;
		logic              last_of_frame;
		logic [BYTE_W-1:0] ver_major;
		logic [BYTE_W-1:0] revision;
	} ifw_result_t;
endpackage
`default_nettype wire

@@ rtl/ifw_parse.sv @@
// parse state registers and per-byte next-state and result logic
`default_nettype none
module ifw_parse (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_fire,
	input  wire logic [ifw_pkg::BYTE_W-1:0] data_byte,
	input  wire logic                       file_start,
	input  wire logic [ifw_pkg::ID_W-1:0]   chosen_frame_id,
	input  wire logic                       select_mode,
	output logic                            res_valid,
	output ifw_pkg::ifw_result_t            res
);
	import ifw_pkg::*;

	phase_t              phase_q, phase_e, phase_n;
	logic [POS_W-1:0]    pos_q, pos_e, pos_n;
	logic [FIELD_W-1:0]  fi_q, fi_e, fi_n;
	logic [SIZE_W-1:0]   tl_q, tl_e, tl_n;
	logic [ID_W-1:0]     id_q, id_e, id_n, id_sh;
	logic [SIZE_W-1:0]   pl_q, pl_e, pl_n, pl_sh;
	logic [15:0]         ver_q, ver_e, ver_n;
	logic                passed_q, passed_e, passed_n;
	logic                at_end, match, sel_match, pl_last;

	// file_start restarts the walk on this very byte
	always_comb begin
		if (file_start) begin
			phase_e  = PH_HEADER;
			pos_e    = '0;
			fi_e     = '0;
			tl_e     = '0;
			id_e     = '0;
			pl_e     = '0;
			ver_e    = '0;
			passed_e = 1'b0;
		end else begin
			phase_e  = phase_q;
			pos_e    = pos_q;
			fi_e     = fi_q;
			tl_e     = tl_q;
			id_e     = id_q;
			pl_e     = pl_q;
			ver_e    = ver_q;
			passed_e = passed_q;
		end
	end

	always_comb begin
		at_end    = ({1'b0, pos_e} >= ({5'd0, tl_e} + HDR_LEN)) || (data_byte == '0);
		match     = (id_e == chosen_frame_id);
		sel_match = select_mode && match;
		pl_last   = (pl_e <= SIZE_W'(1));
		id_sh     = (fi_e == '0) ? {24'd0, data_byte} : {id_e[ID_W-BYTE_W-1:0], data_byte};
		pl_sh     = (fi_e == '0) ? '0 : {pl_e[SIZE_W-8:0], data_byte[6:0]};
	end

	// next state
	always_comb begin
		phase_n  = phase_e;
		pos_n    = pos_e;
		fi_n     = fi_e;
		tl_n     = tl_e;
		id_n     = id_e;
		pl_n     = pl_e;
		ver_n    = ver_e;
		passed_n = passed_e;
		if (phase_e != PH_DONE && pos_e != '1) begin
			pos_n = pos_e + POS_W'(1);
		end
		unique case (phase_e)
			PH_HEADER: begin
				if (fi_e == VER_MAJ_IDX) begin
					ver_n = {data_byte, ver_e[7:0]};
				end else if (fi_e == VER_REV_IDX) begin
					ver_n = {ver_e[15:8], data_byte};
				end else if (fi_e >= SIZE_FIRST_IDX) begin
					tl_n = {tl_e[SIZE_W-8:0], data_byte[6:0]};
				end
				if (fi_e >= HDR_LAST) begin
					phase_n = PH_FRAMEHD;
					fi_n    = '0;
				end else begin
					fi_n = fi_e + FIELD_W'(1);
				end
			end
			PH_FRAMEHD: begin
				if (fi_e == '0 && at_end) begin
					phase_n = PH_DONE;
				end else begin
					if (fi_e == '0) begin
						pl_n = '0;
					end
					if (fi_e < ID_END_IDX) begin
						id_n = id_sh;
					end else if (fi_e < SIZE_END_IDX) begin
						pl_n = pl_sh;
					end
					if (fi_e >= HDR_LAST) begin
						passed_n = select_mode ? match : !match;
						if (pl_e == '0) begin
							if (sel_match) begin
								phase_n = PH_DONE;
							end else begin
								fi_n = '0;
							end
						end else begin
							phase_n = PH_PAYLOAD;
							fi_n    = FLAG_FIRST | (sel_match ? FLAG_STOP : '0);
						end
					end else begin
						fi_n = fi_e + FIELD_W'(1);
					end
				end
			end
			PH_PAYLOAD: begin
				fi_n = fi_e & ~FLAG_FIRST;
				pl_n = pl_last ? '0 : pl_e - SIZE_W'(1);
				if (pl_last) begin
					if ((fi_e & FLAG_STOP) != '0) begin
						phase_n = PH_DONE;
					end else begin
						phase_n = PH_FRAMEHD;
						fi_n    = '0;
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// result
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_e)
			PH_HEADER: begin
				if (fi_e >= HDR_LAST) begin
					res_valid     = 1'b1;
					res.kind      = KIND_VERSION;
					res.ver_major = ver_e[15:8];
					res.revision  = ver_e[7:0];
				end
			end
			PH_FRAMEHD: begin
				if (fi_e >= HDR_LAST && pl_e == '0 && sel_match) begin
					res_valid         = 1'b1;
					res.kind          = KIND_EMPTY;
					res.frame_tag     = id_e;
					res.last_of_frame = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				if (passed_e) begin
					res_valid          = 1'b1;
					res.kind           = KIND_PAYLOAD;
					res.frame_tag      = id_e;
					res.payload_byte   = data_byte;
					res.first_of_frame = fi_e[0];
					res.last_of_frame  = pl_last;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			fi_q     <= '0;
			tl_q     <= '0;
			id_q     <= '0;
			pl_q     <= '0;
			ver_q    <= '0;
			passed_q <= 1'b0;
		end else if (in_fire) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			fi_q     <= fi_n;
			tl_q     <= tl_n;
			id_q     <= id_n;
			pl_q     <= pl_n;
			ver_q    <= ver_n;
			passed_q <= passed_n;
		end
	end
endmodule
`default_nettype wire

@@ rtl/ifw_out_reg.sv @@
// result register between the parser and the output channel
`default_nettype none
module ifw_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 res_valid,
	input  wire ifw_pkg::ifw_result_t res,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ifw_pkg::ifw_result_t      out_res
);
	import ifw_pkg::*;

	logic        valid_q;
	ifw_result_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= res_valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && res_valid) begin
			res_q <= res;
		end
	end
endmodule
`default_nettype wire

@@ rtl/id3v2_frame_walker_core.sv @@
// top level of the id3v2 tag frame walker
//
// Bytes of a file enter on the in channel, one per request, with file_start
// high on byte 0 of a new file. The tag header gives one version result;
// payload bytes of passed frames come out one per request on the out
// channel, with frame_tag, first_of_frame and last_of_frame. In select mode
// a chosen frame with no payload gives one empty marker.
// A result is in the output register on the cycle after its byte is taken.
// Throughput is one byte per cycle while in_ready is high; every byte is
// handled by one pass of counter and compare logic in the parser.
// in_ready is high while the output register is empty or being taken, so a
// stalled receiver holds at most one result and then backpressures input.
// Configuration writes (index 0 chosen frame ID, index 1 select mode) are
// taken at any time; cfg_ready is always high.
// Reset sets the chosen ID to APIC, exclude mode, and the walk to the tag
// header; the output register comes up empty.
`default_nettype none
module id3v2_frame_walker_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ifw_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                          file_start,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ifw_pkg::KIND_W-1:0]         kind,
	output logic [ifw_pkg::ID_W-1:0]           frame_tag,
	output logic [ifw_pkg::BYTE_W-1:0]         payload_byte,
	output logic                               first_of_frame,
	output logic                               last_of_frame,
	output logic [ifw_pkg::BYTE_W-1:0]         ver_major,
	output logic [ifw_pkg::BYTE_W-1:0]         revision,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ifw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ifw_pkg::ID_W-1:0]      cfg_data
);
	import ifw_pkg::*;

	logic [ID_W-1:0] chosen_id_q;
	logic            select_mode_q;
	logic            res_valid;
	ifw_result_t     res;
	ifw_result_t     out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chosen_id_q   <= CHOSEN_ID_RESET;
			select_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CHOSEN_ID:   chosen_id_q   <= cfg_data;
				CFG_SELECT_MODE: select_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	ifw_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_fire         (in_valid && in_ready),
		.data_byte       (data_byte),
		.file_start      (file_start),
		.chosen_frame_id (chosen_id_q),
		.select_mode     (select_mode_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	ifw_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.res_valid (res_valid),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind           = out_res.kind;
	assign frame_tag      = out_res.frame_tag;
	assign payload_byte   = out_res.payload_byte;
	assign first_of_frame = out_res.first_of_frame;
	assign last_of_frame  = out_res.last_of_frame;
	assign ver_major      = out_res.ver_major;
	assign revision       = out_res.revision;
endmodule
`default_nettype wire
